>>> src/vector3_arithmetic_unit_top_macros.svh
// Assertion helpers for the vector arithmetic unit.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef VECTOR3_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define VECTOR3_ARITHMETIC_UNIT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VAU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vau_pkg;

    // Component format: signed fixed point, Q16.16.
    localparam int COMP_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Internal widths that follow from the component format.
    localparam int PROD_WIDTH = 2 * COMP_WIDTH;
    localparam int SUM_WIDTH  = 2 * COMP_WIDTH + 2;
    localparam int QUOT_WIDTH = COMP_WIDTH + FRAC_BITS;

    // Operation codes.
    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_ADD_S  = 4'd2,
        OP_SUB_S  = 4'd3,
        OP_NEG    = 4'd4,
        OP_SCALE  = 4'd5,
        OP_DIV    = 4'd6,
        OP_DOT    = 4'd7,
        OP_CROSS  = 4'd8,
        OP_MAG    = 4'd9,
        OP_MAG_SQ = 4'd10,
        OP_NORM   = 4'd11
    } op_t;

    // One input item.
    typedef struct packed {
        logic [3:0]                   op;
        logic signed [COMP_WIDTH-1:0] ax;
        logic signed [COMP_WIDTH-1:0] ay;
        logic signed [COMP_WIDTH-1:0] az;
        logic signed [COMP_WIDTH-1:0] bx;
        logic signed [COMP_WIDTH-1:0] by_comp;
        logic signed [COMP_WIDTH-1:0] bz;
        logic signed [COMP_WIDTH-1:0] scalar_in;
    } vau_in_t;

    // One result item.
    typedef struct packed {
        logic signed [COMP_WIDTH-1:0] rx;
        logic signed [COMP_WIDTH-1:0] ry;
        logic signed [COMP_WIDTH-1:0] rz;
        logic signed [COMP_WIDTH-1:0] scalar_out;
        logic                         overflow;
        logic                         div_zero;
    } vau_out_t;

    // Operands and partial results that travel down the pipeline.
    typedef struct packed {
        logic [3:0]                  op;
        logic [2:0][COMP_WIDTH-1:0]  a;
        logic [COMP_WIDTH-1:0]       s;
        logic [2:0][COMP_WIDTH-1:0]  r;
        logic [COMP_WIDTH-1:0]       sc;
        logic                        ov;
        logic                        dz;
    } vau_carry_t;

    // A saturated value and its clip flag.
    typedef struct packed {
        logic                  ov;
        logic [COMP_WIDTH-1:0] val;
    } vau_sat_t;

    // Clip a wide signed value to the component range.
    function automatic vau_sat_t saturate(input logic signed [SUM_WIDTH-1:0] v);
        logic signed [SUM_WIDTH-1:0] max_v;
        logic signed [SUM_WIDTH-1:0] min_v;
        vau_sat_t                    res;
        max_v = SUM_WIDTH'({1'b0, {(COMP_WIDTH - 1){1'b1}}});
        min_v = ~max_v;
        if (v > max_v)
        begin
            res.ov  = 1'b1;
            res.val = {1'b0, {(COMP_WIDTH - 1){1'b1}}};
        end
        else if (v < min_v)
        begin
            res.ov  = 1'b1;
            res.val = {1'b1, {(COMP_WIDTH - 1){1'b0}}};
        end
        else
        begin
            res.ov  = 1'b0;
            res.val = v[COMP_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/vector3_arithmetic_unit_top.sv
// Three-component vector arithmetic unit on signed Q16.16 values. It takes one item per
// clock unless the output is stalled and returns one result per item, in order, through
// COMP_WIDTH + COMP_WIDTH + FRAC_BITS + 5 stages. The latency is set by the
// bit-per-stage square root (32 stages, used by magnitude and normalise) followed by the
// bit-per-stage divider (48 stages, three lanes sharing one divisor, used by divide and
// normalise); every item passes through all stages, so latency is the same for every op.
// Products, dot and cross use six 32x32 multipliers in the first stage. The whole
// pipeline moves as one and halts only while a finished result is stalled at the output.
`timescale 1ns / 1ps
`default_nettype none
`include "vector3_arithmetic_unit_top_macros.svh"

module vector3_arithmetic_unit_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  vau_pkg::vau_in_t item,
    output logic             result_valid,
    input  logic             result_stall,
    output vau_pkg::vau_out_t result
);
    import vau_pkg::*;

    localparam int W  = COMP_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = PROD_WIDTH;
    localparam int SW = SUM_WIDTH;
    localparam int QW = QUOT_WIDTH;
    localparam logic signed [SW-1:0] HALF_F = {{(SW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

    // Pipeline advance: everything moves unless a finished result is held.
    logic adv;
    logic out_v_reg;
    vau_out_t out_reg;
    logic [3:0] out_op_reg;

    assign adv          = !out_v_reg || !result_stall;
    assign item_stall   = !adv;
    assign result_valid = out_v_reg;
    assign result       = out_reg;

    // ---------------------------------------------------------------
    // Stage 1: operand select, multipliers, simple add/sub/negate.
    // ---------------------------------------------------------------
    logic signed [W-1:0]  in_a [3];
    logic signed [W-1:0]  in_b [3];
    logic signed [W-1:0]  mul_x [6];
    logic signed [W-1:0]  mul_y [6];
    logic signed [PW-1:0] mul_p [6];
    logic signed [SW-1:0] simple_sum [3];
    vau_sat_t             simple_sat [3];
    vau_carry_t           c1_next;

    always_comb
    begin
        in_a[0] = item.ax;
        in_a[1] = item.ay;
        in_a[2] = item.az;
        in_b[0] = item.bx;
        in_b[1] = item.by_comp;
        in_b[2] = item.bz;

        for (int k = 0; k < 6; k++)
        begin
            mul_x[k] = '0;
            mul_y[k] = '0;
        end

        // Multiplier operands for the product ops.
        unique case (item.op) inside
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_x[i] = in_a[i];
                    mul_y[i] = item.scalar_in;
                end
            end
            OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_x[i] = in_a[i];
                    mul_y[i] = in_b[i];
                end
            end
            OP_CROSS:
            begin
                mul_x[0] = in_a[1];  mul_y[0] = in_b[2];
                mul_x[1] = in_a[2];  mul_y[1] = in_b[1];
                mul_x[2] = in_a[2];  mul_y[2] = in_b[0];
                mul_x[3] = in_a[0];  mul_y[3] = in_b[2];
                mul_x[4] = in_a[0];  mul_y[4] = in_b[1];
                mul_x[5] = in_a[1];  mul_y[5] = in_b[0];
            end
            OP_MAG, OP_MAG_SQ, OP_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_x[i] = in_a[i];
                    mul_y[i] = in_a[i];
                end
            end
            default:
            begin
            end
        endcase

        for (int k = 0; k < 6; k++)
        begin
            mul_p[k] = mul_x[k] * mul_y[k];
        end

        // Per-component add, subtract and negate.
        for (int i = 0; i < 3; i++)
        begin
            unique case (item.op)
                OP_ADD:   simple_sum[i] = SW'(in_a[i]) + SW'(in_b[i]);
                OP_SUB:   simple_sum[i] = SW'(in_a[i]) - SW'(in_b[i]);
                OP_ADD_S: simple_sum[i] = SW'(in_a[i]) + SW'(item.scalar_in);
                OP_SUB_S: simple_sum[i] = SW'(in_a[i]) - SW'(item.scalar_in);
                OP_NEG:   simple_sum[i] = -SW'(in_a[i]);
                default:  simple_sum[i] = '0;
            endcase
            simple_sat[i] = saturate(simple_sum[i]);
        end

        c1_next.op = item.op;
        for (int i = 0; i < 3; i++)
        begin
            c1_next.a[i] = in_a[i];
            c1_next.r[i] = simple_sat[i].val;
        end
        c1_next.s  = item.scalar_in;
        c1_next.sc = '0;
        c1_next.ov = simple_sat[0].ov | simple_sat[1].ov | simple_sat[2].ov;
        c1_next.dz = 1'b0;
    end

    logic                 v1_reg;
    vau_carry_t           c1_reg;
    logic signed [PW-1:0] p1_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= c1_next;
            for (int k = 0; k < 6; k++)
            begin
                p1_reg[k] <= mul_p[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: exact sums of products.
    // ---------------------------------------------------------------
    logic signed [SW-1:0] t2_next [4];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (c1_reg.op == OP_CROSS)
            begin
                t2_next[k] = SW'(p1_reg[2 * k]) - SW'(p1_reg[2 * k + 1]);
            end
            else
            begin
                t2_next[k] = SW'(p1_reg[k]);
            end
        end
        t2_next[3] = SW'(p1_reg[0]) + SW'(p1_reg[1]) + SW'(p1_reg[2]);
    end

    logic                 v2_reg;
    vau_carry_t           c2_reg;
    logic signed [SW-1:0] t2_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg <= c1_reg;
            for (int k = 0; k < 4; k++)
            begin
                t2_reg[k] <= t2_next[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: round to nearest (ties up) and saturate product results.
    // ---------------------------------------------------------------
    logic signed [SW-1:0] rnd [4];
    vau_sat_t             rnd_sat [4];
    vau_carry_t           c3_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rnd[k]     = (t2_reg[k] + HALF_F) >>> F;
            rnd_sat[k] = saturate(rnd[k]);
        end

        c3_next = c2_reg;
        unique case (c2_reg.op) inside
            OP_SCALE, OP_CROSS:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    c3_next.r[k] = rnd_sat[k].val;
                end
                c3_next.ov = rnd_sat[0].ov | rnd_sat[1].ov | rnd_sat[2].ov;
            end
            OP_DOT, OP_MAG_SQ:
            begin
                c3_next.sc = rnd_sat[3].val;
                c3_next.ov = rnd_sat[3].ov;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Square root: one result bit per stage on the sum of squares.
    // Index 0 is the output of stage 3.
    // ---------------------------------------------------------------
    logic          sq_v_reg    [W+1];
    vau_carry_t    sq_c_reg    [W+1];
    logic [PW-1:0] sq_rad_reg  [W+1];
    logic [W:0]    sq_rem_reg  [W+1];
    logic [W-1:0]  sq_root_reg [W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_v_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_c_reg[0]    <= c3_next;
            sq_rad_reg[0]  <= t2_reg[3][PW-1:0];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < W; k++)
    begin : g_sqrt
        logic [W+1:0] cur;
        logic [W+1:0] trial;
        logic [W+1:0] diff;
        logic         take;

        // Bring down the next two radicand bits and try the next root bit.
        always_comb
        begin
            cur   = {sq_rem_reg[k][W-1:0], sq_rad_reg[k][PW-1 -: 2]};
            trial = {sq_root_reg[k], 2'b01};
            diff  = cur - trial;
            take  = (cur >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_c_reg[k+1]    <= sq_c_reg[k];
                sq_rad_reg[k+1]  <= {sq_rad_reg[k][PW-3:0], 2'b00};
                sq_rem_reg[k+1]  <= take ? diff[W:0] : cur[W:0];
                sq_root_reg[k+1] <= {sq_root_reg[k][W-2:0], take};
            end
        end
    end

    // ---------------------------------------------------------------
    // Divider setup: magnitude result, divisor select, zero check.
    // ---------------------------------------------------------------
    logic [W-1:0]           mag;
    vau_sat_t               mag_sat;
    logic [W-1:0]           s_mag;
    logic [W-1:0]           a_mag [3];
    vau_carry_t             dv_c_next;
    logic                   dv_go_next;
    logic [W-1:0]           dv_d_next;
    logic [2:0][QW-1:0]     dv_num_next;
    logic [2:0]             dv_neg_next;

    always_comb
    begin
        mag     = sq_root_reg[W];
        mag_sat = saturate($signed(SW'({1'b0, mag})));
        s_mag   = sq_c_reg[W].s[W-1] ? (-sq_c_reg[W].s) : sq_c_reg[W].s;

        dv_c_next  = sq_c_reg[W];
        dv_go_next = 1'b0;
        dv_d_next  = '0;

        unique case (sq_c_reg[W].op)
            OP_MAG:
            begin
                dv_c_next.sc = mag_sat.val;
                dv_c_next.ov = mag_sat.ov;
            end
            OP_DIV:
            begin
                if (sq_c_reg[W].s == '0)
                begin
                    dv_c_next.dz = 1'b1;
                end
                else
                begin
                    dv_go_next = 1'b1;
                    dv_d_next  = s_mag;
                end
            end
            OP_NORM:
            begin
                if (mag == '0)
                begin
                    dv_c_next.dz = 1'b1;
                end
                else
                begin
                    dv_go_next = 1'b1;
                    dv_d_next  = mag;
                end
            end
            default:
            begin
            end
        endcase

        // Dividends are the component magnitudes shifted up by the fraction width.
        for (int j = 0; j < 3; j++)
        begin
            a_mag[j] = sq_c_reg[W].a[j][W-1] ? (-sq_c_reg[W].a[j]) : sq_c_reg[W].a[j];
            dv_num_next[j] = {a_mag[j], {F{1'b0}}};
            dv_neg_next[j] = sq_c_reg[W].a[j][W-1]
                           ^ ((sq_c_reg[W].op == OP_DIV) && sq_c_reg[W].s[W-1]);
        end
    end

    // ---------------------------------------------------------------
    // Divider: one quotient bit per stage in each of three lanes.
    // ---------------------------------------------------------------
    logic               dv_v_reg   [QW+1];
    vau_carry_t         dv_c_reg   [QW+1];
    logic               dv_go_reg  [QW+1];
    logic [W-1:0]       dv_d_reg   [QW+1];
    logic [2:0][QW-1:0] dv_num_reg [QW+1];
    logic [2:0][W-1:0]  dv_rem_reg [QW+1];
    logic [2:0]         dv_neg_reg [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_v_reg[0] <= sq_v_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_c_reg[0]   <= dv_c_next;
            dv_go_reg[0]  <= dv_go_next;
            dv_d_reg[0]   <= dv_d_next;
            dv_num_reg[0] <= dv_num_next;
            dv_rem_reg[0] <= '0;
            dv_neg_reg[0] <= dv_neg_next;
        end
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        logic [W:0]         cur  [3];
        logic [W:0]         diff [3];
        logic [2:0]         take;
        logic [2:0][QW-1:0] num_next;
        logic [2:0][W-1:0]  rem_next;

        // Restoring step: subtract the divisor when it fits.
        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                cur[j]      = {dv_rem_reg[k][j], dv_num_reg[k][j][QW-1]};
                diff[j]     = cur[j] - {1'b0, dv_d_reg[k]};
                take[j]     = (cur[j] >= {1'b0, dv_d_reg[k]});
                rem_next[j] = take[j] ? diff[j][W-1:0] : cur[j][W-1:0];
                num_next[j] = {dv_num_reg[k][j][QW-2:0], take[j]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_c_reg[k+1]   <= dv_c_reg[k];
                dv_go_reg[k+1]  <= dv_go_reg[k];
                dv_d_reg[k+1]   <= dv_d_reg[k];
                dv_num_reg[k+1] <= num_next;
                dv_rem_reg[k+1] <= rem_next;
                dv_neg_reg[k+1] <= dv_neg_reg[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Final stage: apply quotient signs, saturate, build the result.
    // ---------------------------------------------------------------
    logic signed [SW-1:0] q_ext [3];
    logic signed [SW-1:0] q_val [3];
    vau_sat_t             q_sat [3];
    vau_carry_t           fin;
    vau_out_t             out_next;

    always_comb
    begin
        fin = dv_c_reg[QW];
        for (int j = 0; j < 3; j++)
        begin
            q_ext[j] = $signed(SW'({1'b0, dv_num_reg[QW][j]}));
            q_val[j] = dv_neg_reg[QW][j] ? -q_ext[j] : q_ext[j];
            q_sat[j] = saturate(q_val[j]);
        end
        if (dv_go_reg[QW])
        begin
            for (int j = 0; j < 3; j++)
            begin
                fin.r[j] = q_sat[j].val;
            end
            fin.ov = q_sat[0].ov | q_sat[1].ov | q_sat[2].ov;
        end

        out_next.rx         = fin.r[0];
        out_next.ry         = fin.r[1];
        out_next.rz         = fin.r[2];
        out_next.scalar_out = fin.sc;
        out_next.overflow   = fin.ov;
        out_next.div_zero   = fin.dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= dv_v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg    <= out_next;
            out_op_reg <= fin.op;
        end
    end

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    // A zero divisor clears every value and never reports a clip.
    `VAU_ASSERT_NOW(a_dz_clears, out_v_reg && out_reg.div_zero,
        out_reg.rx == '0 && out_reg.ry == '0 && out_reg.rz == '0
            && out_reg.scalar_out == '0 && !out_reg.overflow,
        "divide by zero result is not all zero")

    // Only divide and normalise can flag a zero divisor.
    `VAU_ASSERT_NOW(a_dz_op, out_v_reg && out_reg.div_zero,
        out_op_reg == OP_DIV || out_op_reg == OP_NORM,
        "div_zero raised for an op without a divisor")

    // Scalar ops leave the result vector at zero.
    `VAU_ASSERT_NOW(a_scalar_vec_zero,
        out_v_reg && (out_op_reg == OP_DOT || out_op_reg == OP_MAG || out_op_reg == OP_MAG_SQ),
        out_reg.rx == '0 && out_reg.ry == '0 && out_reg.rz == '0,
        "scalar op produced a nonzero vector")

    // A held result freezes the front of the pipeline.
    `VAU_ASSERT_NEXT(a_hold_front, out_v_reg && result_stall,
        $stable(v1_reg) && $stable(sq_v_reg[0]) && $stable(dv_v_reg[0]),
        "pipeline moved while the result was stalled")

endmodule

`default_nettype wire
